[src/pgpl_pkg.sv]
package pgpl_pkg;

    localparam int PIX_W   = 8;
    localparam int GAMMA_W = 12;
    localparam int LOG_W   = 35;
    localparam int NUM_PIX = 1 << PIX_W;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 12'd256;

    typedef logic [LOG_W-1:0] log_tab_t [NUM_PIX];
    typedef logic [31:0]      c_tab_t   [32];

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOG  = 4'b0010,
        ST_EXP  = 4'b0100,
        ST_WR   = 4'b1000
    } fill_state_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-(32-i)) in q0.32 for fraction bit i
    function automatic c_tab_t build_c_tab();
        c_tab_t      t;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 31; i >= 0; i--) begin
            c    = isqrt64(c << 32);
            t[i] = c[31:0];
        end
        return t;
    endfunction

    // log2(255/x) in q.32, entry 0 unused
    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] k;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] m;
        logic [63:0] frac;
        t[0] = '0;
        for (int x = 1; x < NUM_PIX; x++) begin
            k = 64'd0;
            while (k < 64'd7 && ((64'(x) << (k + 1)) <= 64'd255))
                k = k + 64'd1;
            num = 64'd255 << 31;
            den = 64'(x) << k;
            rem = 64'd0;
            m   = 64'd0;
            for (int b = 40; b >= 0; b--) begin
                rem = (rem << 1) | 64'(num[b]);
                m   = m << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    m   = m | 64'd1;
                end
            end
            frac = 64'd0;
            for (int i = 31; i >= 0; i--) begin
                m = (m * m) >> 31;
                if (m >= (64'd1 << 32)) begin
                    m    = m >> 1;
                    frac = frac | (64'd1 << i);
                end
            end
            t[x] = {k[2:0], frac[31:0]};
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam c_tab_t   C_TAB   = build_c_tab();

endpackage

[src/pixel_gamma_power_law_top.sv]
// power-law gamma mapping of an 8-bit grayscale pixel stream
// input channel s_valid/s_ready carries s_pixel_in and s_last_in, result
// channel m_valid/m_ready carries m_pixel_out and m_last_out (copy of last)
// cfg_wr_en/cfg_wr_data write the q4.8 exponent, accepted any cycle; write only when idle
// the mapping lives in a 256 x 8 lookup memory; the read data register
// is the output register, so a result shows in the cycle after its pixel
// is taken; one pixel every clock while idle and the result side keeps up
// after reset and after every exponent write the memory is rebuilt,
// entry by entry (one log-times-gamma multiply, 32 steps of the
// shared exp2 multiplier, one write), with s_ready low
// reset exponent is 1.0
// a stalled result holds the output register and drops s_ready, as does a rebuild
module pixel_gamma_power_law_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pgpl_pkg::GAMMA_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pgpl_pkg::PIX_W-1:0]     s_pixel_in,
    input  logic                           s_last_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pgpl_pkg::PIX_W-1:0]     m_pixel_out,
    output logic                           m_last_out
);
    import pgpl_pkg::*;

    logic [PIX_W-1:0]   lut_mem [NUM_PIX];

    fill_state_t        state_reg, state_next;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [PIX_W-1:0]   x_reg;
    logic [4:0]         bit_reg;
    logic [38:0]        e_reg;
    logic [32:0]        acc_reg;
    logic               m_valid_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               last_reg;

    logic               advance;
    logic               s_accept;
    logic [46:0]        e_prod;
    logic [64:0]        acc_prod;
    logic [6:0]         n_val;
    logic [41:0]        y_sum;
    logic [41:0]        y_shift;
    logic [5:0]         sh_amt;
    logic [PIX_W-1:0]   y_val;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && advance;
    assign s_accept = s_valid && s_ready;

    assign e_prod   = 47'(gamma_reg) * 47'(LOG_TAB[x_reg]);
    assign acc_prod = 65'(acc_reg) * 65'(C_TAB[bit_reg]);
    assign n_val    = e_reg[38:32];
    assign sh_amt   = 6'd32 + {2'b00, n_val[3:0]};
    assign y_sum    = 42'd255 * 42'(acc_reg) + (42'd1 << (6'd31 + {2'b00, n_val[3:0]}));
    assign y_shift  = y_sum >> sh_amt;

    always_comb begin
        priority if (x_reg == '0) begin
            y_val = (gamma_reg == '0) ? 8'd255 : 8'd0;
        end else if (n_val >= 7'd9) begin
            y_val = 8'd0;
        end else if (y_shift > 42'd255) begin
            y_val = 8'd255;
        end else begin
            y_val = y_shift[PIX_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_LOG:  state_next = ST_EXP;
            ST_EXP:  state_next = (bit_reg == '0) ? ST_WR : ST_EXP;
            ST_WR:   state_next = (x_reg == '1) ? ST_IDLE : ST_LOG;
            default: state_next = ST_LOG;
        endcase
        if (cfg_wr_en) begin
            state_next = ST_LOG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOG;
            gamma_reg   <= GAMMA_RESET;
            x_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                gamma_reg <= cfg_wr_data;
                x_reg     <= '0;
            end else if (state_reg == ST_WR) begin
                x_reg <= x_reg + 1'b1;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // exponent datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOG) begin
            e_reg   <= e_prod[46:8];
            acc_reg <= 33'h1_0000_0000;
            bit_reg <= 5'd31;
        end else if (state_reg == ST_EXP) begin
            if (e_reg[bit_reg]) begin
                acc_reg <= acc_prod[64:32];
            end
            bit_reg <= bit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) begin
            lut_mem[x_reg] <= y_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg  <= lut_mem[s_pixel_in];
            last_reg <= s_last_in;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = pix_reg;
    assign m_last_out  = last_reg;

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input taken during table rebuild");

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted pixel produced no result");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

endmodule
